// ----- rtl/tblr_pkg.sv -----
// Shared types and constants of the tile background line renderer.
`timescale 1ns / 1ps

package tblr_pkg;

  localparam int unsigned VRAM_BYTES   = 8192;
  localparam int unsigned VRAM_AW      = $clog2(VRAM_BYTES);
  localparam int unsigned TOTAL_LINES  = 154;
  localparam int unsigned TILE_COLUMNS = 20;
  localparam int unsigned LINE_W       = 8;
  localparam int unsigned COL_W        = 5;
  localparam int unsigned SHADES_W     = 16;
  localparam int unsigned PAL_W        = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned OUT_TDATA_W  = 32;

  localparam logic [VRAM_AW-1:0] MAP0_OFS  = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP1_OFS  = 13'h1C00;
  localparam logic [VRAM_AW-1:0] UDATA_OFS = 13'h0000;
  localparam logic [VRAM_AW-1:0] SDATA_OFS = 13'h1000;
  localparam logic [LINE_W-1:0]  VBLANK_LINE = LINE_W'(18 * 8);
  localparam logic [LINE_W-1:0]  LAST_LINE   = LINE_W'(TOTAL_LINES - 1);
  localparam logic [COL_W-1:0]   LAST_COL    = COL_W'(TILE_COLUMNS - 1);
  localparam logic [PAL_W-1:0]   PAL_RESET   = 8'd252;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_ENABLE   = 2'd0,
    CFG_MAP_SELECT  = 2'd1,
    CFG_DATA_SELECT = 2'd2,
    CFG_BG_PALETTE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_LO,
    ST_HI,
    ST_PIX,
    ST_BLANK
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic wr_en;
    logic tick_start;
    logic rd_map;
    logic rd_lo;
    logic rd_hi;
    logic load_pix;
    logic load_blank;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic bg_enable;
    logic in_vblank;
    logic last_col;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- rtl/tblr_ctrl.sv -----
// Sequencer that steps the renderer through clearing, writes and line ticks.
`timescale 1ns / 1ps

module tblr_ctrl
  import tblr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   tick_go;

  assign tick_go = in_valid_i && (op_e'(in_op_i) == OP_TICK) && sts_i.bg_enable;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick_go) begin
          state_d = sts_i.in_vblank ? ST_BLANK : ST_MAP;
        end
      end
      ST_MAP:  state_d = ST_LO;
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = ST_PIX;
      ST_PIX: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last_col ? ST_IDLE : ST_LO;
        end
      end
      ST_BLANK: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.wr_en      = in_valid_i && (op_e'(in_op_i) == OP_WRITE);
        cmd_o.tick_start = tick_go;
      end
      ST_MAP: cmd_o.rd_map = 1'b1;
      ST_LO:  cmd_o.rd_lo  = 1'b1;
      ST_HI:  cmd_o.rd_hi  = 1'b1;
      ST_PIX: begin
        cmd_o.load_pix = sts_i.out_free;
        cmd_o.rd_map   = sts_i.out_free && !sts_i.last_col;
      end
      ST_BLANK: cmd_o.load_blank = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/tblr_dp.sv -----
// Datapath with the video store, line state, configuration and result register.
`timescale 1ns / 1ps

module tblr_dp
  import tblr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [VRAM_AW-1:0]     wr_addr_i,
  input  logic [7:0]             wr_data_i,
  input  ctrl_cmd_t              cmd_i,
  output ctrl_sts_t              sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [LINE_W-1:0]      out_line_o,
  output logic [COL_W-1:0]       out_col_o,
  output logic [SHADES_W-1:0]    out_shades_o,
  output logic                   out_pix_o,
  output logic                   out_vblank_o,
  output logic                   out_last_o
);

  logic                 bg_enable_q, map_sel_q, data_sel_q;
  logic [PAL_W-1:0]     palette_q;
  logic [VRAM_AW-1:0]   clr_cnt_q;
  logic [LINE_W-1:0]    line_cnt_q, line_next, cur_line_q;
  logic                 vblank_q, vblank_d;
  logic [COL_W-1:0]     col_q, map_col;

  logic [7:0]           mem [VRAM_BYTES];
  logic [7:0]           rdata_q, lo_q;
  logic [VRAM_AW-1:0]   tile_addr_q, map_addr, tile_base, lo_addr, rd_addr;
  logic                 rd_en;
  logic [SHADES_W-1:0]  shades;

  logic                 out_valid_q;
  logic [LINE_W-1:0]    out_line_q;
  logic [COL_W-1:0]     out_col_q;
  logic [SHADES_W-1:0]  out_shades_q;
  logic                 out_pix_q, out_vblank_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_enable_q <= 1'b1;
      map_sel_q   <= 1'b0;
      data_sel_q  <= 1'b1;
      palette_q   <= PAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_BG_ENABLE:   bg_enable_q <= cfg_data_i[0];
        CFG_MAP_SELECT:  map_sel_q   <= cfg_data_i[0];
        CFG_DATA_SELECT: data_sel_q  <= cfg_data_i[0];
        CFG_BG_PALETTE:  palette_q   <= cfg_data_i[PAL_W-1:0];
      endcase
    end
  end

  assign line_next = (line_cnt_q == LAST_LINE) ? '0 : line_cnt_q + LINE_W'(1);

  always_comb begin
    vblank_d = vblank_q;
    if (line_next == VBLANK_LINE) begin
      vblank_d = 1'b1;
    end else if (line_next == '0) begin
      vblank_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      line_cnt_q <= '0;
      cur_line_q <= '0;
      vblank_q   <= 1'b0;
      col_q      <= '0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + VRAM_AW'(1);
      end
      if (cmd_i.tick_start) begin
        cur_line_q <= line_cnt_q;
        line_cnt_q <= line_next;
        vblank_q   <= vblank_d;
        col_q      <= '0;
      end else if (cmd_i.load_pix) begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  assign map_col  = cmd_i.load_pix ? col_q + COL_W'(1) : col_q;
  assign map_addr = (map_sel_q ? MAP1_OFS : MAP0_OFS)
                  + VRAM_AW'({cur_line_q[LINE_W-1:3], 5'b00000})
                  + VRAM_AW'(map_col);

  assign tile_base = data_sel_q ? (UDATA_OFS + VRAM_AW'({rdata_q, 4'b0000}))
                                : (SDATA_OFS + {rdata_q[7], rdata_q, 4'b0000});
  assign lo_addr   = tile_base + VRAM_AW'({cur_line_q[2:0], 1'b0});

  always_comb begin
    priority if (cmd_i.rd_lo) begin
      rd_addr = lo_addr;
    end else if (cmd_i.rd_hi) begin
      rd_addr = tile_addr_q + VRAM_AW'(1);
    end else begin
      rd_addr = map_addr;
    end
  end

  assign rd_en = cmd_i.rd_map || cmd_i.rd_lo || cmd_i.rd_hi;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_lo) begin
      tile_addr_q <= lo_addr;
    end
    if (cmd_i.rd_hi) begin
      lo_q <= rdata_q;
    end
  end

  always_comb begin
    logic [1:0] colour;
    shades = '0;
    for (int p = 0; p < 8; p++) begin
      colour = {rdata_q[7-p], lo_q[7-p]};
      shades[2*p +: 2] = palette_q[2*colour +: 2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_pix || cmd_i.load_blank) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      out_line_q   <= cur_line_q;
      out_col_q    <= col_q;
      out_shades_q <= shades;
      out_pix_q    <= 1'b1;
      out_vblank_q <= vblank_q;
      out_last_q   <= (col_q == LAST_COL);
    end else if (cmd_i.load_blank) begin
      out_line_q   <= cur_line_q;
      out_col_q    <= '0;
      out_shades_q <= '0;
      out_pix_q    <= 1'b0;
      out_vblank_q <= vblank_q;
      out_last_q   <= 1'b1;
    end
  end

  assign sts_o.clear_done = (clr_cnt_q == '1);
  assign sts_o.bg_enable  = bg_enable_q;
  assign sts_o.in_vblank  = vblank_q;
  assign sts_o.last_col   = (col_q == LAST_COL);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_line_o   = out_line_q;
  assign out_col_o    = out_col_q;
  assign out_shades_o = out_shades_q;
  assign out_pix_o    = out_pix_q;
  assign out_vblank_o = out_vblank_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/tile_background_line_renderer_unit.sv -----
// Top level of the tile background line renderer.
// A video memory write transaction is taken one per cycle while idle.
// A line tick outside vertical blank presents one result per tile column, each column
// needing three reads of the single store port (map entry, low byte, high byte), and
// no transaction is taken until its last result is loaded; a tick in vertical blank
// presents a single blank result instead.
// After reset all 8192 bytes of the store are cleared, and no transaction is taken until then.
`timescale 1ns / 1ps

module tile_background_line_renderer_unit
  import tblr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // vram_addr, vram_data, zero pad
  input  logic                   s_axis_tuser,   // op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // line, tile_column, shades, vblank_flag, pad
  output logic                   m_axis_tuser,   // pixels_valid
  output logic                   m_axis_tlast
);

  ctrl_cmd_t            cmd;
  ctrl_sts_t            sts;
  logic [LINE_W-1:0]    out_line;
  logic [COL_W-1:0]     out_col;
  logic [SHADES_W-1:0]  out_shades;
  logic                 out_vblank;

  tblr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tblr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .wr_addr_i    (s_axis_tdata[VRAM_AW-1:0]),
    .wr_data_i    (s_axis_tdata[VRAM_AW+7:VRAM_AW]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_line_o   (out_line),
    .out_col_o    (out_col),
    .out_shades_o (out_shades),
    .out_pix_o    (m_axis_tuser),
    .out_vblank_o (out_vblank),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_vblank, out_shades, out_col, out_line};

endmodule

// ----- verif/tblr_line_checker.sv -----
// Scoreboard that predicts and checks the rendered background line results.
`timescale 1ns / 1ps

module tblr_line_checker
  import tblr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // vram_addr, vram_data, zero pad
  input  logic                   s_axis_tuser,   // op
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // line, tile_column, shades, vblank_flag, pad
  input  logic                   m_axis_tuser,   // pixels_valid
  input  logic                   m_axis_tlast,
  output int                     fail_count_o,
  output int                     pending_o,
  output logic [LINE_W-1:0]      line_o
);

  typedef struct packed {
    logic [LINE_W-1:0]   line_no;
    logic [COL_W-1:0]    column;
    logic [SHADES_W-1:0] shades;
    logic                pix_valid;
    logic                vblank;
    logic                last;
  } tile_shades_t;

  logic [7:0]       vram_q [VRAM_BYTES];
  logic [LINE_W-1:0] line_q;
  logic             vblank_q;
  logic             bg_en_q;
  logic             map_sel_q;
  logic             data_sel_q;
  logic [PAL_W-1:0] pal_q;
  tile_shades_t     shades_fifo [$];

  assign line_o = line_q;

  always @(posedge clk_i or negedge rst_ni) begin
    tile_shades_t      got;
    tile_shades_t      want;
    logic [VRAM_AW-1:0] map_addr;
    logic [VRAM_AW-1:0] tile_addr;
    logic [7:0]        code;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [1:0]        cnum;
    logic [LINE_W-1:0] cur;
    logic              drawing;
    if (!rst_ni) begin
      for (int i = 0; i < VRAM_BYTES; i++) vram_q[i] = '0;
      line_q = '0;
      vblank_q = 1'b0;
      bg_en_q = 1'b1;
      map_sel_q = 1'b0;
      data_sel_q = 1'b1;
      pal_q = PAL_RESET;
      shades_fifo.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.line_no = m_axis_tdata[7:0];
        got.column = m_axis_tdata[12:8];
        got.shades = m_axis_tdata[28:13];
        got.vblank = m_axis_tdata[29];
        got.pix_valid = m_axis_tuser;
        got.last = m_axis_tlast;
        if (shades_fifo.size() == 0) begin
          $error("unexpected result: line %0d, column %0d", got.line_no, got.column);
          fail_count_o++;
        end else begin
          want = shades_fifo.pop_front();
          if (got.line_no !== want.line_no) begin
            $error("line: expected %0d, got %0d", want.line_no, got.line_no);
            fail_count_o++;
          end
          if (got.column !== want.column) begin
            $error("tile_column: expected %0d, got %0d", want.column, got.column);
            fail_count_o++;
          end
          if (got.shades !== want.shades) begin
            $error("shades: expected %h, got %h", want.shades, got.shades);
            fail_count_o++;
          end
          if (got.pix_valid !== want.pix_valid) begin
            $error("pixels_valid: expected %0d, got %0d", want.pix_valid, got.pix_valid);
            fail_count_o++;
          end
          if (got.vblank !== want.vblank) begin
            $error("vblank_flag: expected %0d, got %0d", want.vblank, got.vblank);
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BG_ENABLE:   bg_en_q = cfg_data_i[0];
          CFG_MAP_SELECT:  map_sel_q = cfg_data_i[0];
          CFG_DATA_SELECT: data_sel_q = cfg_data_i[0];
          CFG_BG_PALETTE:  pal_q = cfg_data_i[PAL_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (op_e'(s_axis_tuser) == OP_WRITE) begin
          vram_q[s_axis_tdata[12:0]] = s_axis_tdata[20:13];
        end else if (bg_en_q) begin
          cur = line_q;
          drawing = !vblank_q;
          line_q = (cur == LAST_LINE) ? '0 : cur + LINE_W'(1);
          if (line_q == VBLANK_LINE) vblank_q = 1'b1;
          else if (line_q == '0) vblank_q = 1'b0;
          if (!drawing) begin
            want = '{line_no: cur, column: '0, shades: '0, pix_valid: 1'b0,
                     vblank: vblank_q, last: 1'b1};
            shades_fifo.push_back(want);
          end else begin
            for (int c = 0; c < TILE_COLUMNS; c++) begin
              map_addr = (map_sel_q ? MAP1_OFS : MAP0_OFS) + VRAM_AW'({cur[7:3], 5'd0})
                       + VRAM_AW'(c);
              code = vram_q[map_addr];
              tile_addr = data_sel_q ? UDATA_OFS + {1'b0, code, 4'd0}
                                     : SDATA_OFS + {code[7], code, 4'd0};
              tile_addr = tile_addr + VRAM_AW'({cur[2:0], 1'b0});
              lo = vram_q[tile_addr];
              hi = vram_q[tile_addr + VRAM_AW'(1)];
              want.shades = '0;
              for (int p = 0; p < 8; p++) begin
                cnum = {hi[7-p], lo[7-p]};
                want.shades[2*p +: 2] = pal_q[2*cnum +: 2];
              end
              want.line_no = cur;
              want.column = COL_W'(c);
              want.pix_valid = 1'b1;
              want.vblank = vblank_q;
              want.last = (COL_W'(c) == LAST_COL);
              shades_fifo.push_back(want);
            end
          end
        end
      end
      pending_o = shades_fifo.size();
    end
  end

endmodule

// ----- verif/tb_tile_background_line_renderer_unit.sv -----
// Stimulus, clock, reset and final verdict for the tile background line renderer.
`timescale 1ns / 1ps

module tb_tile_background_line_renderer_unit;
  import tblr_pkg::*;

  localparam int QUIET_CYCLES = 80;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 40000;
  localparam int MIN_LINE_TICKS = 175;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  int                fail_count;
  int                pending;
  logic [LINE_W-1:0] line_seen;

  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  bit         bg_en_now = 1'b1;
  int         line_ticks = 0;
  logic [7:0] tile_pool [4];

  always #4 clk = ~clk;

  tile_background_line_renderer_unit uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  tblr_line_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .line_o        (line_seen)
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= snk_stall_pct);

  task automatic send_item(input op_e op, input logic [VRAM_AW-1:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= IN_TDATA_W'({data, addr});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_TICK && bg_en_now) line_ticks++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BG_ENABLE) bg_en_now = val[0];
  endtask

  // Most writes land on the map row and tile row that the next tick will fetch.
  task automatic random_item();
    int                 r;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         code;
    logic [4:0]         row;
    r = $urandom_range(99);
    code = tile_pool[$urandom_range(3)];
    row = (line_seen < VBLANK_LINE) ? line_seen[7:3] : 5'($urandom_range(17));
    if (r < 55) begin
      send_item(OP_TICK, VRAM_AW'($urandom), 8'($urandom));
    end else if (r < 72) begin
      if ($urandom_range(4) == 0) code = 8'($urandom);
      send_item(OP_WRITE, {2'b11, 1'($urandom), row, 5'($urandom_range(19))}, code);
    end else if (r < 92) begin
      addr = ($urandom_range(1) == 1) ? UDATA_OFS + {1'b0, code, 4'd0}
                                       : SDATA_OFS + {code[7], code, 4'd0};
      send_item(OP_WRITE, addr + VRAM_AW'({line_seen[2:0], 1'($urandom)}), 8'($urandom));
    end else begin
      send_item(OP_WRITE, VRAM_AW'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input int n_items);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    tile_pool = '{8'($urandom), 8'h80, 8'hFF, 8'($urandom)};
    repeat (n_items) random_item();
  endtask

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Tiles with codes at the signed and unsigned boundaries, checked with reset settings.
    send_item(OP_WRITE, MAP0_OFS, 8'h80);
    send_item(OP_WRITE, MAP0_OFS + 13'd1, 8'h7F);
    send_item(OP_WRITE, MAP0_OFS + 13'd19, 8'hFF);
    send_item(OP_WRITE, 13'h0800, 8'hA5);
    send_item(OP_WRITE, 13'h0801, 8'h3C);
    send_item(OP_WRITE, 13'h0FF0, 8'hFF);
    send_item(OP_WRITE, 13'h0FF1, 8'h00);
    send_item(OP_WRITE, 13'h07F0, 8'h55);
    send_item(OP_WRITE, 13'h07F1, 8'hAA);
    send_item(OP_WRITE, 13'h17F0, 8'h0F);
    send_item(OP_WRITE, 13'h17F1, 8'hF0);
    send_item(OP_WRITE, 13'h0000, 8'hFF);
    send_item(OP_WRITE, 13'h1FFF, 8'h00);
    send_item(OP_TICK, '0, '0);

    write_reg(CFG_DATA_SELECT, 8'd0);
    send_item(OP_WRITE, 13'h0802, 8'hC3);
    send_item(OP_WRITE, 13'h17F2, 8'h81);
    send_item(OP_TICK, 13'h1FFF, 8'hFF);

    write_reg(CFG_MAP_SELECT, 8'd1);
    write_reg(CFG_BG_PALETTE, 8'hFF);
    send_item(OP_TICK, '0, '0);

    write_reg(CFG_BG_ENABLE, 8'd0);
    send_item(OP_TICK, '0, '0);
    write_reg(CFG_BG_ENABLE, 8'd1);
    write_reg(CFG_BG_PALETTE, 8'h00);
    send_item(OP_TICK, '0, '0);

    write_reg(CFG_MAP_SELECT, 8'd0);
    write_reg(CFG_DATA_SELECT, 8'd1);
    write_reg(CFG_BG_PALETTE, 8'hE4);
    run_phase(0, 0, 75);

    write_reg(CFG_MAP_SELECT, 8'd1);
    write_reg(CFG_DATA_SELECT, 8'd0);
    write_reg(CFG_BG_PALETTE, 8'($urandom));
    run_phase(57, 0, 75);

    write_reg(CFG_MAP_SELECT, 8'd0);
    write_reg(CFG_BG_PALETTE, 8'h1B);
    run_phase(0, 57, 75);

    write_reg(CFG_BG_ENABLE, 8'd0);
    run_phase(13, 13, 8);
    write_reg(CFG_BG_ENABLE, 8'd1);
    write_reg(CFG_MAP_SELECT, 8'd1);
    write_reg(CFG_DATA_SELECT, 8'd1);
    write_reg(CFG_BG_PALETTE, 8'($urandom));
    run_phase(13, 13, 75);
    while (line_ticks < MIN_LINE_TICKS) random_item();

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
